// ===== src/mos6502_register_alu_execute_core_defines.svh =====
// ----------------------------------------------------------------------------
// execute core assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef MOS6502_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH
`define MOS6502_REGISTER_ALU_EXECUTE_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define REX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define REX_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rex_pkg.sv =====
// ----------------------------------------------------------------------------
// rex_pkg
// operation codes, flag positions and shared types of the execute core
// ----------------------------------------------------------------------------
`default_nettype none
package rex_pkg;

	typedef enum logic [5:0] {
		OP_ORA = 6'd0,  OP_AND = 6'd1,  OP_EOR = 6'd2,  OP_ADC = 6'd3,
		OP_SBC = 6'd4,  OP_STA = 6'd5,  OP_STX = 6'd6,  OP_STY = 6'd7,
		OP_LDA = 6'd8,  OP_LDX = 6'd9,  OP_LDY = 6'd10, OP_INC = 6'd11,
		OP_INX = 6'd12, OP_INY = 6'd13, OP_DEC = 6'd14, OP_DEX = 6'd15,
		OP_DEY = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
		OP_BIT = 6'd20, OP_ASL = 6'd21, OP_LSR = 6'd22, OP_ROL = 6'd23,
		OP_ROR = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
		OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_PHA = 6'd31,
		OP_PHP = 6'd32, OP_PLA = 6'd33, OP_PLP = 6'd34, OP_CLC = 6'd35,
		OP_CLD = 6'd36, OP_CLI = 6'd37, OP_CLV = 6'd38, OP_SEC = 6'd39,
		OP_SED = 6'd40, OP_SEI = 6'd41, OP_NOP = 6'd42, OP_BRK = 6'd43,
		OP_JMP = 6'd44, OP_BCC = 6'd45, OP_BCS = 6'd46, OP_BEQ = 6'd47,
		OP_BNE = 6'd48, OP_BMI = 6'd49, OP_BPL = 6'd50, OP_BVS = 6'd51,
		OP_BVC = 6'd52, OP_JSR = 6'd53, OP_RTS = 6'd54, OP_RTI = 6'd55
	} op_t;

	localparam int unsigned FN = 7;
	localparam int unsigned FV = 6;
	localparam int unsigned FU = 5;
	localparam int unsigned FB = 4;
	localparam int unsigned FD = 3;
	localparam int unsigned FI = 2;
	localparam int unsigned FZ = 1;
	localparam int unsigned FC = 0;

	localparam logic [7:0] SP_RESET    = 8'hFD;
	localparam logic [7:0] FLAGS_RESET = 8'h04;
	localparam logic [7:0] PULL_MASK   = 8'hCF;
	localparam logic [7:0] PUSH_BITS   = 8'h30;

	// decoded item handed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] operand;
		logic       on_acc;
	} dec_item_t;

	typedef struct packed {
		logic [7:0] write_data;
		logic       write_enable;
		logic       branch_taken;
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] status;
		logic       decimal_fault;
	} res_item_t;

endpackage
`default_nettype wire

// ===== src/rex_front.sv =====
// ----------------------------------------------------------------------------
// rex_front
// two-entry queue of decoded items
// ----------------------------------------------------------------------------
`default_nettype none
module rex_front import rex_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [5:0] opcode,
	input  wire logic [7:0] operand,
	input  wire logic       on_accumulator,
	output logic            dq_valid,
	output dec_item_t       dq_item,
	input  wire logic       dq_take
);

	dec_item_t  mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;
	dec_item_t  d;

	always_comb begin
		d.op      = op_t'(opcode);
		d.operand = operand;
		d.on_acc  = on_accumulator;
		// unused codes behave as nop
		if (opcode > OP_RTI) begin
			d.op = OP_NOP;
		end
	end

	assign full     = (cnt_q == 2'd2);
	assign dq_valid = (cnt_q != 2'd0);
	assign dq_item  = mem_q[rp_q];
	assign wr       = push && !full;
	assign rd       = dq_take && dq_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule
`default_nettype wire

// ===== src/rex_back.sv =====
// ----------------------------------------------------------------------------
// rex_back
// register file, alu and flag update, two-entry result queue
// ----------------------------------------------------------------------------
`default_nettype none
module rex_back import rex_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       dq_valid,
	input  dec_item_t       dq_item,
	output logic            dq_take,
	output logic            empty,
	input  wire logic       pop,
	output res_item_t       res
);

	logic [7:0] a_q, x_q, y_q, sp_q, f_q;
	logic [7:0] a_n, x_n, y_n, sp_n, f_n;
	logic [7:0] wd, src, sres, m, cmpr;
	logic       we, tk, flt, shf, cin;
	logic [8:0] sum, diff;
	res_item_t  rq_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign dq_take = dq_valid && (cnt_q != 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign res     = rq_q[rp_q];
	assign rd      = pop && !empty;

	always_comb begin
		m    = dq_item.operand;
		a_n  = a_q; x_n = x_q; y_n = y_q; sp_n = sp_q; f_n = f_q;
		wd   = 8'd0; we = 1'b0; tk = 1'b0; flt = 1'b0; shf = 1'b0;
		sres = 8'd0;
		cin  = f_q[FC];
		src  = dq_item.on_acc ? a_q : m;
		sum  = {1'b0, a_q} + {1'b0, (dq_item.op == OP_ADC) ? m : ~m} + {8'd0, cin};
		cmpr = (dq_item.op == OP_CMP) ? a_q : ((dq_item.op == OP_CPX) ? x_q : y_q);
		diff = {1'b0, cmpr} - {1'b0, m};
		case (dq_item.op)
			OP_ORA: a_n = a_q | m;
			OP_AND: a_n = a_q & m;
			OP_EOR: a_n = a_q ^ m;
			OP_ADC, OP_SBC: begin
				if (f_q[FD]) begin
					flt = 1'b1;
				end else begin
					a_n = sum[7:0];
					f_n[FC] = sum[8];
					f_n[FV] = ~(a_q[7] ^ m[7] ^ (dq_item.op == OP_SBC)) & (a_q[7] ^ sum[7]);
				end
			end
			OP_STA: begin wd = a_q; we = 1'b1; end
			OP_STX: begin wd = x_q; we = 1'b1; end
			OP_STY: begin wd = y_q; we = 1'b1; end
			OP_LDA: a_n = m;
			OP_PLA: begin a_n = m; sp_n = sp_q + 8'd1; end
			OP_LDX: x_n = m;
			OP_LDY: y_n = m;
			OP_INC: begin wd = m + 8'd1; we = 1'b1; end
			OP_INX: x_n = x_q + 8'd1;
			OP_INY: y_n = y_q + 8'd1;
			OP_DEC: begin wd = m - 8'd1; we = 1'b1; end
			OP_DEX: x_n = x_q - 8'd1;
			OP_DEY: y_n = y_q - 8'd1;
			OP_CMP, OP_CPX, OP_CPY: f_n[FC] = ~diff[8];
			OP_BIT: begin
				f_n[FN] = m[7]; f_n[FV] = m[6]; f_n[FZ] = ((m & a_q) == 8'd0);
			end
			OP_ASL: begin shf = 1'b1; f_n[FC] = src[7]; sres = {src[6:0], 1'b0}; end
			OP_LSR: begin shf = 1'b1; f_n[FC] = src[0]; sres = {1'b0, src[7:1]}; end
			OP_ROL: begin shf = 1'b1; f_n[FC] = src[7]; sres = {src[6:0], cin}; end
			OP_ROR: begin shf = 1'b1; f_n[FC] = src[0]; sres = {cin, src[7:1]}; end
			OP_TAX: x_n = a_q;
			OP_TAY: y_n = a_q;
			OP_TXA: a_n = x_q;
			OP_TYA: a_n = y_q;
			OP_TSX: x_n = sp_q;
			OP_TXS: sp_n = x_q;
			OP_PHA: begin wd = a_q; we = 1'b1; sp_n = sp_q - 8'd1; end
			OP_PHP: begin wd = f_q | PUSH_BITS; we = 1'b1; sp_n = sp_q - 8'd1; end
			OP_PLP: begin f_n = m & PULL_MASK; sp_n = sp_q + 8'd1; end
			OP_CLC: f_n[FC] = 1'b0;
			OP_CLD: f_n[FD] = 1'b0;
			OP_CLI: f_n[FI] = 1'b0;
			OP_CLV: f_n[FV] = 1'b0;
			OP_SEC: f_n[FC] = 1'b1;
			OP_SED: f_n[FD] = 1'b1;
			OP_SEI: f_n[FI] = 1'b1;
			OP_BRK: begin
				wd = f_q | PUSH_BITS; we = 1'b1; sp_n = sp_q - 8'd3;
				f_n[FI] = 1'b1; tk = 1'b1;
			end
			OP_JMP: tk = 1'b1;
			OP_BCC: tk = ~f_q[FC];
			OP_BCS: tk = f_q[FC];
			OP_BEQ: tk = f_q[FZ];
			OP_BNE: tk = ~f_q[FZ];
			OP_BMI: tk = f_q[FN];
			OP_BPL: tk = ~f_q[FN];
			OP_BVS: tk = f_q[FV];
			OP_BVC: tk = ~f_q[FV];
			OP_JSR: begin sp_n = sp_q - 8'd2; tk = 1'b1; end
			OP_RTS: begin sp_n = sp_q + 8'd2; tk = 1'b1; end
			OP_RTI: begin f_n = m & PULL_MASK; sp_n = sp_q + 8'd3; tk = 1'b1; end
			default: ;
		endcase
		// n and z from the value produced
		case (dq_item.op)
			OP_ORA, OP_AND, OP_EOR, OP_LDA, OP_PLA, OP_TXA, OP_TYA: begin
				f_n[FN] = a_n[7]; f_n[FZ] = (a_n == 8'd0);
			end
			OP_ADC, OP_SBC: begin
				if (!f_q[FD]) begin
					f_n[FN] = a_n[7]; f_n[FZ] = (a_n == 8'd0);
				end
			end
			OP_LDX, OP_INX, OP_DEX, OP_TAX, OP_TSX: begin
				f_n[FN] = x_n[7]; f_n[FZ] = (x_n == 8'd0);
			end
			OP_LDY, OP_INY, OP_DEY, OP_TAY: begin
				f_n[FN] = y_n[7]; f_n[FZ] = (y_n == 8'd0);
			end
			OP_INC, OP_DEC: begin
				f_n[FN] = wd[7]; f_n[FZ] = (wd == 8'd0);
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				f_n[FN] = diff[7]; f_n[FZ] = (diff[7:0] == 8'd0);
			end
			default: ;
		endcase
		if (shf) begin
			f_n[FN] = sres[7];
			f_n[FZ] = (sres == 8'd0);
			if (dq_item.on_acc) begin
				a_n = sres;
			end else begin
				wd = sres; we = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= 8'd0;
			x_q  <= 8'd0;
			y_q  <= 8'd0;
			sp_q <= SP_RESET;
			f_q  <= FLAGS_RESET;
		end else if (dq_take) begin
			a_q  <= a_n;
			x_q  <= x_n;
			y_q  <= y_n;
			sp_q <= sp_n;
			f_q  <= f_n;
		end
	end

	always_ff @(posedge clk) begin
		if (dq_take) begin
			rq_q[wp_q] <= '{write_data: wd, write_enable: we, branch_taken: tk,
				acc: a_n, x: x_n, y: y_n, sp: sp_n, status: f_n, decimal_fault: flt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (dq_take) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, dq_take} - {1'b0, rd};
		end
	end

endmodule
`default_nettype wire

// ===== src/mos6502_register_alu_execute_core.sv =====
// ----------------------------------------------------------------------------
// mos6502_register_alu_execute_core
// register and alu execute core with queue interfaces on both sides
// ----------------------------------------------------------------------------
// path: each item is registered in the decode queue, then in the result queue
// throughput: one item per cycle when not stalled by a full result queue
// a two-entry decode queue and a two-entry result queue absorb stalls
// reset: a, x, y cleared, stack pointer 0xfd, only i set, both queues empty
`default_nettype none
module mos6502_register_alu_execute_core import rex_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [5:0] opcode,
	input  wire logic [7:0] operand,
	input  wire logic       on_accumulator,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      write_data,
	output logic            write_enable,
	output logic            branch_taken,
	output logic [7:0]      acc_out,
	output logic [7:0]      x_out,
	output logic [7:0]      y_out,
	output logic [7:0]      sp_out,
	output logic [7:0]      status_out,
	output logic            decimal_fault
);

	logic      dq_valid, dq_take;
	dec_item_t dq_item;
	res_item_t res;

	rex_front u_front (
		.clk, .arst_n, .push, .full, .opcode, .operand, .on_accumulator,
		.dq_valid, .dq_item, .dq_take
	);

	rex_back u_back (
		.clk, .arst_n, .dq_valid, .dq_item, .dq_take, .empty, .pop, .res
	);

	assign write_data    = res.write_data;
	assign write_enable  = res.write_enable;
	assign branch_taken  = res.branch_taken;
	assign acc_out       = res.acc;
	assign x_out         = res.x;
	assign y_out         = res.y;
	assign sp_out        = res.sp;
	assign status_out    = res.status;
	assign decimal_fault = res.decimal_fault;

endmodule
`default_nettype wire

// ===== src/rex_checker.sv =====
// ----------------------------------------------------------------------------
// rex_checker
// port-level checks of the execute core
// ----------------------------------------------------------------------------
`default_nettype none
`include "mos6502_register_alu_execute_core_defines.svh"
module rex_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic       write_enable,
	input wire logic [7:0] write_data,
	input wire logic [7:0] status_out,
	input wire logic       decimal_fault,
	input wire logic [7:0] acc_out
);

	`REX_ASSERT_IMP(a_unused_bits, clk, arst_n, !empty, status_out[5:4] == 2'b00, "bits 5 and 4 set")
	`REX_ASSERT_IMP(a_wdata_zero, clk, arst_n, !empty && !write_enable, write_data == 8'd0, "stray data")
	`REX_ASSERT_IMP(a_fault_dmode, clk, arst_n, !empty && decimal_fault, status_out[3], "fault without d")
	`REX_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(acc_out), "result dropped")

endmodule

bind mos6502_register_alu_execute_core rex_checker u_rex_checker (
	.clk, .arst_n, .empty, .pop, .write_enable, .write_data, .status_out,
	.decimal_fault, .acc_out
);
`default_nettype wire

// ===== test/mos6502_register_alu_execute_core_tb.sv =====
// ----------------------------------------------------------------------------
// mos6502_register_alu_execute_core_tb
// drives decoded instructions through the execute core and checks every
// result against a register and flag predictor, with random idling on both
// sides, a directed table up front, a sweep of all 64 codes and a long random run
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module mos6502_register_alu_execute_core_tb;
	import rex_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 820;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [5:0] op;
		logic [7:0] opnd;
		logic       on_acc;
		logic       has_known;
		res_item_t  known;
	} instr_row_t;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [5:0] opcode;
	logic [7:0] operand;
	logic       on_accumulator;
	logic       empty;
	logic       pop;
	logic [7:0] write_data;
	logic       write_enable;
	logic       branch_taken;
	logic [7:0] acc_out;
	logic [7:0] x_out;
	logic [7:0] y_out;
	logic [7:0] sp_out;
	logic [7:0] status_out;
	logic       decimal_fault;

	logic [7:0] reg_a, reg_x, reg_y, reg_sp, reg_p;
	res_item_t  expected_results[$];
	instr_row_t directed_rows[$];
	int unsigned mismatch_count;
	int unsigned idle_cycles;
	bit          stimulus_done;

	mos6502_register_alu_execute_core u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.opcode(opcode), .operand(operand), .on_accumulator(on_accumulator),
		.empty(empty), .pop(pop), .write_data(write_data),
		.write_enable(write_enable), .branch_taken(branch_taken),
		.acc_out(acc_out), .x_out(x_out), .y_out(y_out), .sp_out(sp_out),
		.status_out(status_out), .decimal_fault(decimal_fault)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] update_nz(logic [7:0] v);
		reg_p[FN] = v[7];
		reg_p[FZ] = (v == 8'h00);
		return v;
	endfunction

	function automatic res_item_t execute_instr(logic [5:0] op, logic [7:0] m, logic on_acc);
		res_item_t r;
		logic [7:0] src, sh, opnd2;
		logic [8:0] sum;
		logic cin, shifted;
		r = '0;
		src = on_acc ? reg_a : m;
		cin = reg_p[FC];
		shifted = 1'b0;
		sh = 8'h00;
		case (op)
			OP_ORA: reg_a = update_nz(reg_a | m);
			OP_AND: reg_a = update_nz(reg_a & m);
			OP_EOR: reg_a = update_nz(reg_a ^ m);
			OP_ADC, OP_SBC: begin
				if (reg_p[FD]) begin
					r.decimal_fault = 1'b1;
				end else begin
					opnd2 = (op == OP_ADC) ? m : ~m;
					sum = {1'b0, reg_a} + {1'b0, opnd2} + {8'h00, cin};
					reg_p[FC] = sum[8];
					reg_p[FV] = ~(reg_a[7] ^ opnd2[7]) & (reg_a[7] ^ sum[7]);
					reg_a = update_nz(sum[7:0]);
				end
			end
			OP_STA: begin r.write_data = reg_a; r.write_enable = 1'b1; end
			OP_STX: begin r.write_data = reg_x; r.write_enable = 1'b1; end
			OP_STY: begin r.write_data = reg_y; r.write_enable = 1'b1; end
			OP_LDA: reg_a = update_nz(m);
			OP_LDX: reg_x = update_nz(m);
			OP_LDY: reg_y = update_nz(m);
			OP_INC: begin r.write_data = update_nz(m + 8'd1); r.write_enable = 1'b1; end
			OP_INX: reg_x = update_nz(reg_x + 8'd1);
			OP_INY: reg_y = update_nz(reg_y + 8'd1);
			OP_DEC: begin r.write_data = update_nz(m - 8'd1); r.write_enable = 1'b1; end
			OP_DEX: reg_x = update_nz(reg_x - 8'd1);
			OP_DEY: reg_y = update_nz(reg_y - 8'd1);
			OP_CMP, OP_CPX, OP_CPY: begin
				opnd2 = (op == OP_CMP) ? reg_a : (op == OP_CPX) ? reg_x : reg_y;
				reg_p[FC] = (opnd2 >= m);
				void'(update_nz(opnd2 - m));
			end
			OP_BIT: begin
				reg_p[FN] = m[7];
				reg_p[FV] = m[6];
				reg_p[FZ] = ((m & reg_a) == 8'h00);
			end
			OP_ASL: begin reg_p[FC] = src[7]; sh = src << 1; shifted = 1'b1; end
			OP_LSR: begin reg_p[FC] = src[0]; sh = src >> 1; shifted = 1'b1; end
			OP_ROL: begin reg_p[FC] = src[7]; sh = {src[6:0], cin}; shifted = 1'b1; end
			OP_ROR: begin reg_p[FC] = src[0]; sh = {cin, src[7:1]}; shifted = 1'b1; end
			OP_TAX: reg_x = update_nz(reg_a);
			OP_TAY: reg_y = update_nz(reg_a);
			OP_TXA: reg_a = update_nz(reg_x);
			OP_TYA: reg_a = update_nz(reg_y);
			OP_TSX: reg_x = update_nz(reg_sp);
			OP_TXS: reg_sp = reg_x;
			OP_PHA: begin
				r.write_data = reg_a; r.write_enable = 1'b1; reg_sp = reg_sp - 8'd1;
			end
			OP_PHP: begin
				r.write_data = reg_p | PUSH_BITS; r.write_enable = 1'b1;
				reg_sp = reg_sp - 8'd1;
			end
			OP_PLA: begin reg_a = update_nz(m); reg_sp = reg_sp + 8'd1; end
			OP_PLP: begin reg_p = m & PULL_MASK; reg_sp = reg_sp + 8'd1; end
			OP_CLC: reg_p[FC] = 1'b0;
			OP_CLD: reg_p[FD] = 1'b0;
			OP_CLI: reg_p[FI] = 1'b0;
			OP_CLV: reg_p[FV] = 1'b0;
			OP_SEC: reg_p[FC] = 1'b1;
			OP_SED: reg_p[FD] = 1'b1;
			OP_SEI: reg_p[FI] = 1'b1;
			OP_BRK: begin
				r.write_data = reg_p | PUSH_BITS; r.write_enable = 1'b1;
				reg_sp = reg_sp - 8'd3; reg_p[FI] = 1'b1; r.branch_taken = 1'b1;
			end
			OP_JMP: r.branch_taken = 1'b1;
			OP_BCC: r.branch_taken = !reg_p[FC];
			OP_BCS: r.branch_taken = reg_p[FC];
			OP_BEQ: r.branch_taken = reg_p[FZ];
			OP_BNE: r.branch_taken = !reg_p[FZ];
			OP_BMI: r.branch_taken = reg_p[FN];
			OP_BPL: r.branch_taken = !reg_p[FN];
			OP_BVS: r.branch_taken = reg_p[FV];
			OP_BVC: r.branch_taken = !reg_p[FV];
			OP_JSR: begin reg_sp = reg_sp - 8'd2; r.branch_taken = 1'b1; end
			OP_RTS: begin reg_sp = reg_sp + 8'd2; r.branch_taken = 1'b1; end
			OP_RTI: begin
				reg_p = m & PULL_MASK; reg_sp = reg_sp + 8'd3; r.branch_taken = 1'b1;
			end
			default: ;
		endcase
		if (shifted) begin
			void'(update_nz(sh));
			if (on_acc) begin
				reg_a = sh;
			end else begin
				r.write_data = sh;
				r.write_enable = 1'b1;
			end
		end
		r.acc = reg_a;
		r.x = reg_x;
		r.y = reg_y;
		r.sp = reg_sp;
		r.status = reg_p;
		return r;
	endfunction

	function automatic void add_row(logic [5:0] op, logic [7:0] m, logic on_acc);
		instr_row_t row;
		row.op = op; row.opnd = m; row.on_acc = on_acc;
		row.has_known = 1'b0; row.known = '0;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_known_row(logic [5:0] op, logic [7:0] m, logic on_acc,
			res_item_t k);
		instr_row_t row;
		row.op = op; row.opnd = m; row.on_acc = on_acc;
		row.has_known = 1'b1; row.known = k;
		directed_rows.push_back(row);
	endfunction

	task automatic send_instr(logic [5:0] op, logic [7:0] m, logic on_acc);
		int unsigned gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		operand <= m;
		on_accumulator <= on_acc;
		do @(posedge clk); while (full);
		expected_results.push_back(execute_instr(op, m, on_acc));
		@(negedge clk);
	endtask

	function automatic logic [5:0] pick_opcode();
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 4)
			return 6'($urandom_range(56, 63));
		if (sel < 12)
			return ($urandom_range(0, 1) == 0) ? OP_ADC : OP_SBC;
		if (sel < 16)
			return OP_CLD;
		return 6'($urandom_range(0, 55));
	endfunction

	initial begin
		res_item_t k;
		instr_row_t row;
		arst_n = 1'b0;
		push = 1'b0;
		opcode = '0;
		operand = '0;
		on_accumulator = 1'b0;
		stimulus_done = 1'b0;
		mismatch_count = 0;
		reg_a = 8'h00; reg_x = 8'h00; reg_y = 8'h00;
		reg_sp = SP_RESET; reg_p = FLAGS_RESET;

		// state just after reset, seen through a no-op and stores
		k = '0; k.sp = SP_RESET; k.status = FLAGS_RESET;
		add_known_row(OP_NOP, 8'hFF, 1'b1, k);
		k.write_enable = 1'b1;
		add_known_row(OP_STA, 8'hFF, 1'b0, k);
		k.write_data = FLAGS_RESET | PUSH_BITS; k.sp = SP_RESET - 8'd1;
		add_known_row(OP_PHP, 8'h00, 1'b0, k);
		add_row(OP_LDA, 8'h80, 1'b0);
		add_row(OP_ADC, 8'h80, 1'b0);
		add_row(OP_ADC, 8'hFF, 1'b0);
		add_row(OP_SBC, 8'h7F, 1'b0);
		add_row(OP_SED, 8'h00, 1'b0);
		add_row(OP_ADC, 8'h01, 1'b0);
		add_row(OP_SBC, 8'h01, 1'b0);
		add_row(OP_CLD, 8'h00, 1'b0);
		add_row(OP_ROL, 8'hFF, 1'b1);
		add_row(OP_ROR, 8'h01, 1'b0);
		add_row(OP_LDX, 8'h00, 1'b0);
		add_row(OP_DEX, 8'h00, 1'b0);
		add_row(OP_TXS, 8'h00, 1'b0);
		add_row(OP_TSX, 8'h00, 1'b0);
		add_row(OP_PLA, 8'h00, 1'b0);
		add_row(OP_PLP, 8'hFF, 1'b0);
		add_row(OP_BRK, 8'h00, 1'b0);
		add_row(OP_RTI, 8'h30, 1'b0);
		add_row(OP_JSR, 8'h00, 1'b0);
		add_row(OP_RTS, 8'h00, 1'b0);
		add_row(6'd63, 8'hAA, 1'b1);
		add_row(OP_BIT, 8'hC0, 1'b0);
		add_row(OP_TYA, 8'h00, 1'b0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			send_instr(row.op, row.opnd, row.on_acc);
			if (row.has_known && expected_results[$] !== row.known) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("table row %0d: predictor gives %p, typed value %p", i,
						expected_results[$], row.known);
			end
		end
		for (int op = 0; op < 64; op++)
			send_instr(6'(op), 8'($urandom), 1'($urandom));

		// hold off until the core has drained
		push <= 1'b0;
		@(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++)
			send_instr(pick_opcode(), 8'($urandom), 1'($urandom));
		push <= 1'b0;
		stimulus_done = 1'b1;
	end

	initial begin
		int unsigned wait_cycles;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (wait_cycles != 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	always @(posedge clk) begin
		res_item_t got, want;
		if (arst_n && pop && !empty) begin
			got.write_data = write_data;
			got.write_enable = write_enable;
			got.branch_taken = branch_taken;
			got.acc = acc_out;
			got.x = x_out;
			got.y = y_out;
			got.sp = sp_out;
			got.status = status_out;
			got.decimal_fault = decimal_fault;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected item: %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p, actual %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else if (stimulus_done && expected_results.size() == 0) begin
				repeat (20) @(posedge clk);
				if (mismatch_count == 0 && expected_results.size() == 0)
					$display("Simulation PASSED");
				else
					$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
